// File: rtl/assert_macros.svh
// Assertion helpers clocked on i_clk and held off during reset.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// cond must never be true.
`define KRSK_ASSERT_NEVER(lbl, cond) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) !(cond)) \
        else $error("assertion failed: forbidden condition seen");

// whenever cond holds, prop holds in the same cycle.
`define KRSK_ASSERT_IMPLY(lbl, cond, prop) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (cond) |-> (prop)) \
        else $error("assertion failed: implication violated");

`endif

// File: rtl/krsk_pkg.sv
`default_nettype none
package krsk_pkg;

    localparam int NODE_FIELD_W = 6;
    localparam int IN_WEIGHT_W  = 32;
    localparam int RANK_W       = 3;
    localparam int RANK_MAX     = 7;
    localparam int MAX_RESULTS  = 63;
    localparam int RES_CNT_W    = 6;
    localparam int QUEUE_DEPTH  = 4;
    localparam int QUEUE_PTR_W  = 2;

    typedef struct packed {
        logic [NODE_FIELD_W-1:0] edge_from;
        logic [NODE_FIELD_W-1:0] edge_to;
        logic [IN_WEIGHT_W-1:0]  edge_weight;
        logic                    last_edge;
    } t_edge;

    typedef struct packed {
        logic [NODE_FIELD_W-1:0] tree_from;
        logic [NODE_FIELD_W-1:0] tree_to;
        logic [IN_WEIGHT_W-1:0]  tree_weight;
        logic                    tree_valid;
        logic                    tree_last;
        logic                    edges_dropped;
    } t_tree;

    // queue entry: the edge, whether it goes to the store, and the run's drop flag
    typedef struct packed {
        t_edge ed;
        logic  keep;
        logic  dropped;
    } t_qent;

endpackage
`default_nettype wire

// File: rtl/krsk_edge_if.sv
`default_nettype none
interface krsk_edge_if;
    logic            valid;
    logic            ready;
    krsk_pkg::t_edge data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface
`default_nettype wire

// File: rtl/krsk_tree_if.sv
`default_nettype none
interface krsk_tree_if;
    logic            valid;
    logic            ready;
    krsk_pkg::t_tree data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface
`default_nettype wire

// File: rtl/krsk_front.sv
`default_nettype none
module krsk_front #(
    parameter int MAX_EDGES = 256
) (
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    krsk_edge_if.sink       i_edge,
    input  wire logic       i_full,
    output logic            o_push,
    output krsk_pkg::t_qent o_ent
);

    localparam int CNT_W = $clog2(MAX_EDGES + 1);

    logic [CNT_W-1:0] r_cnt;
    logic             r_ovf;
    logic             accept;
    logic             keep;

    assign i_edge.ready = !i_full;
    assign accept       = i_edge.valid && !i_full;
    assign keep         = r_cnt != CNT_W'(MAX_EDGES);

    // a dropped edge vanishes unless it closes the set
    assign o_push      = accept && (keep || i_edge.data.last_edge);
    assign o_ent.ed    = i_edge.data;
    assign o_ent.keep  = keep;
    assign o_ent.dropped = r_ovf || !keep;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= '0;
            r_ovf <= 1'b0;
        end else if (accept) begin
            if (i_edge.data.last_edge) begin
                r_cnt <= '0;
                r_ovf <= 1'b0;
            end else if (keep) begin
                r_cnt <= r_cnt + CNT_W'(1);
            end else begin
                r_ovf <= 1'b1;
            end
        end
    end

endmodule
`default_nettype wire

// File: rtl/krsk_fifo.sv
`default_nettype none
module krsk_fifo (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_push,
    input  wire krsk_pkg::t_qent  i_data,
    output logic                  o_full,
    output logic                  o_valid,
    output krsk_pkg::t_qent       o_data,
    input  wire logic             i_pop
);

    localparam int PW = krsk_pkg::QUEUE_PTR_W;

    krsk_pkg::t_qent r_mem [krsk_pkg::QUEUE_DEPTH];
    logic [PW-1:0]   r_wp;
    logic [PW-1:0]   r_rp;
    logic [PW:0]     r_cnt;
    logic            do_push;
    logic            do_pop;

    assign o_full  = r_cnt == (PW+1)'(krsk_pkg::QUEUE_DEPTH);
    assign o_valid = r_cnt != '0;
    assign o_data  = r_mem[r_rp];
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && o_valid;

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wp] <= i_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            if (do_push) begin
                r_wp <= r_wp + PW'(1);
            end
            if (do_pop) begin
                r_rp <= r_rp + PW'(1);
            end
            if (do_push && !do_pop) begin
                r_cnt <= r_cnt + (PW+1)'(1);
            end else if (do_pop && !do_push) begin
                r_cnt <= r_cnt - (PW+1)'(1);
            end
        end
    end

endmodule
`default_nettype wire

// File: rtl/krsk_back.sv
`default_nettype none
module krsk_back #(
    parameter int MAX_NODES   = 64,
    parameter int MAX_EDGES   = 256,
    parameter int WEIGHT_BITS = 32
) (
    input  wire logic            i_clk,
    input  wire logic            i_rst_n,
    input  wire logic            i_valid,
    input  wire krsk_pkg::t_qent i_ent,
    output logic                 o_pop,
    krsk_tree_if.source          o_tree
);

    localparam int IDX_W  = $clog2(MAX_EDGES);
    localparam int CNT_W  = $clog2(MAX_EDGES + 1);
    localparam int NODE_W = $clog2(MAX_NODES);
    localparam int FW     = krsk_pkg::NODE_FIELD_W;
    localparam int RW     = krsk_pkg::RANK_W;
    localparam int RCW    = krsk_pkg::RES_CNT_W;

    typedef struct packed {
        logic [FW-1:0]          f;
        logic [FW-1:0]          t;
        logic [WEIGHT_BITS-1:0] w;
    } t_rec;

    typedef struct packed {
        logic [RW-1:0]     rank;
        logic [NODE_W-1:0] parent;
    } t_uf;

    typedef enum logic [3:0] {
        S_LOAD, S_RI, S_RJ, S_RW, S_OK, S_OE, S_EG,
        S_FA, S_FAW, S_FB, S_FBW, S_JN, S_JR, S_PUSH, S_END
    } t_state;

    t_state r_state;

    // stores
    t_rec             edge_mem  [MAX_EDGES];
    logic [IDX_W-1:0] order_mem [MAX_EDGES];
    t_uf              uf_mem    [MAX_NODES];
    logic [MAX_NODES-1:0] r_ufv;

    t_rec             r_rda;
    t_rec             r_rdb;
    logic [IDX_W-1:0] r_ordq;
    t_uf              r_ufq;

    logic [CNT_W-1:0]  r_cnt;
    logic              r_ovf;
    logic [IDX_W-1:0]  r_i;
    logic [CNT_W-1:0]  r_j;
    logic              r_pv;
    logic [IDX_W-1:0]  r_pj;
    logic [IDX_W-1:0]  r_rank;
    logic [IDX_W-1:0]  r_k;
    logic [NODE_W-1:0] r_x;
    logic [NODE_W-1:0] r_ra;
    logic [NODE_W-1:0] r_rb;
    logic [RW-1:0]     r_rka;
    logic [RW-1:0]     r_rkb;
    t_rec              r_e;
    t_rec              r_pend;
    logic              r_pend_v;
    logic [RCW-1:0]    r_nres;
    logic              r_ov;
    krsk_pkg::t_tree   r_od;

    logic              edge_we;
    t_rec              edge_wd;
    logic              rea;
    logic [IDX_W-1:0]  addra;
    logic              reb;
    logic              ord_we;
    logic              ord_re;
    logic              uf_re;
    logic              uf_we;
    logic [NODE_W-1:0] uf_wa;
    t_uf               uf_wd;
    logic              uf_clr;
    logic              last_k;
    logic              out_free;
    logic              emit;
    logic              ahead;
    logic              nodes_ok;
    logic              is_root;
    logic [RW-1:0]     root_rank;

    assign o_tree.valid = r_ov;
    assign o_tree.data  = r_od;
    assign out_free     = !r_ov || o_tree.ready;
    assign o_pop        = (r_state == S_LOAD) && i_valid;

    // load the output register this cycle
    assign emit = ((r_state == S_PUSH) && r_pend_v && out_free)
                  || ((r_state == S_END) && out_free);

    assign edge_we   = o_pop && i_ent.keep;
    assign edge_wd.f = i_ent.ed.edge_from;
    assign edge_wd.t = i_ent.ed.edge_to;
    assign edge_wd.w = WEIGHT_BITS'(48'(i_ent.ed.edge_weight));

    assign rea    = (r_state == S_RI) || (r_state == S_OE);
    assign addra  = (r_state == S_RI) ? r_i : r_ordq;
    assign reb    = (r_state == S_RJ) && (r_j != r_cnt);
    assign ord_we = r_state == S_RW;
    assign ord_re = r_state == S_OK;
    assign uf_re  = (r_state == S_FA) || (r_state == S_FB);
    assign uf_clr = (r_state == S_END) && out_free;

    assign last_k = (CNT_W'(r_k) + CNT_W'(1)) == r_cnt;

    // stable order: earlier arrival wins a tie
    assign ahead = (r_rdb.w < r_rda.w) || ((r_rdb.w == r_rda.w) && (r_pj < r_i));

    assign nodes_ok = (32'(r_rda.f) < 32'(MAX_NODES)) && (32'(r_rda.t) < 32'(MAX_NODES))
                      && (r_nres != RCW'(krsk_pkg::MAX_RESULTS));

    // an unwritten node is its own root with rank zero
    assign is_root   = !r_ufv[r_x] || (r_ufq.parent == r_x);
    assign root_rank = r_ufv[r_x] ? r_ufq.rank : '0;

    always_comb begin
        uf_we = 1'b0;
        uf_wa = r_ra;
        uf_wd = '{rank: r_rka, parent: r_ra};
        case (r_state)
            S_JN: begin
                if (r_ra != r_rb) begin
                    uf_we = 1'b1;
                    if (r_rka < r_rkb) begin
                        uf_wa = r_ra;
                        uf_wd = '{rank: r_rka, parent: r_rb};
                    end else begin
                        uf_wa = r_rb;
                        uf_wd = '{rank: r_rkb, parent: r_ra};
                    end
                end
            end
            S_JR: begin
                uf_we = 1'b1;
                uf_wa = r_ra;
                uf_wd = '{rank: r_rka + RW'(1), parent: r_ra};
            end
            default: begin
                uf_we = 1'b0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (edge_we) begin
            edge_mem[r_cnt[IDX_W-1:0]] <= edge_wd;
        end
        if (rea) begin
            r_rda <= edge_mem[addra];
        end
        if (reb) begin
            r_rdb <= edge_mem[r_j[IDX_W-1:0]];
        end
    end

    always_ff @(posedge i_clk) begin
        if (ord_we) begin
            order_mem[r_rank] <= r_i;
        end
        if (ord_re) begin
            r_ordq <= order_mem[r_k];
        end
    end

    always_ff @(posedge i_clk) begin
        if (uf_we) begin
            uf_mem[uf_wa] <= uf_wd;
        end
        if (uf_re) begin
            r_ufq <= uf_mem[r_x];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ufv <= '0;
        end else if (uf_clr) begin
            r_ufv <= '0;
        end else if (uf_we) begin
            r_ufv[uf_wa] <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_LOAD;
            r_cnt    <= '0;
            r_pv     <= 1'b0;
            r_pend_v <= 1'b0;
            r_ov     <= 1'b0;
        end else begin
            if (emit) begin
                r_ov <= 1'b1;
            end else if (o_tree.ready) begin
                r_ov <= 1'b0;
            end
            case (r_state)
                S_LOAD: begin
                    if (i_valid) begin
                        if (i_ent.keep) begin
                            r_cnt <= r_cnt + CNT_W'(1);
                        end
                        if (i_ent.ed.last_edge) begin
                            r_ovf   <= i_ent.dropped;
                            r_i     <= '0;
                            r_state <= S_RI;
                        end
                    end
                end
                S_RI: begin
                    r_j     <= '0;
                    r_pv    <= 1'b0;
                    r_rank  <= '0;
                    r_state <= S_RJ;
                end
                S_RJ: begin
                    // stream every weight past the held one and count those ahead of it
                    if (r_j != r_cnt) begin
                        r_j  <= r_j + CNT_W'(1);
                        r_pv <= 1'b1;
                        r_pj <= r_j[IDX_W-1:0];
                    end else begin
                        r_pv <= 1'b0;
                    end
                    if (r_pv && ahead) begin
                        r_rank <= r_rank + IDX_W'(1);
                    end
                    if ((r_j == r_cnt) && !r_pv) begin
                        r_state <= S_RW;
                    end
                end
                S_RW: begin
                    if ((CNT_W'(r_i) + CNT_W'(1)) == r_cnt) begin
                        r_k      <= '0;
                        r_nres   <= '0;
                        r_pend_v <= 1'b0;
                        r_state  <= S_OK;
                    end else begin
                        r_i     <= r_i + IDX_W'(1);
                        r_state <= S_RI;
                    end
                end
                S_OK: begin
                    r_state <= S_OE;
                end
                S_OE: begin
                    r_state <= S_EG;
                end
                S_EG: begin
                    r_e <= r_rda;
                    if (nodes_ok) begin
                        r_x     <= NODE_W'(32'(r_rda.f));
                        r_state <= S_FA;
                    end else if (last_k) begin
                        r_state <= S_END;
                    end else begin
                        r_k     <= r_k + IDX_W'(1);
                        r_state <= S_OK;
                    end
                end
                S_FA: begin
                    r_state <= S_FAW;
                end
                S_FAW: begin
                    if (is_root) begin
                        r_ra    <= r_x;
                        r_rka   <= root_rank;
                        r_x     <= NODE_W'(32'(r_e.t));
                        r_state <= S_FB;
                    end else begin
                        r_x     <= r_ufq.parent;
                        r_state <= S_FA;
                    end
                end
                S_FB: begin
                    r_state <= S_FBW;
                end
                S_FBW: begin
                    if (is_root) begin
                        r_rb    <= r_x;
                        r_rkb   <= root_rank;
                        r_state <= S_JN;
                    end else begin
                        r_x     <= r_ufq.parent;
                        r_state <= S_FB;
                    end
                end
                S_JN: begin
                    if (r_ra == r_rb) begin
                        if (last_k) begin
                            r_state <= S_END;
                        end else begin
                            r_k     <= r_k + IDX_W'(1);
                            r_state <= S_OK;
                        end
                    end else if ((r_rka == r_rkb) && (r_rka != RW'(krsk_pkg::RANK_MAX))) begin
                        r_state <= S_JR;
                    end else begin
                        r_state <= S_PUSH;
                    end
                end
                S_JR: begin
                    r_state <= S_PUSH;
                end
                S_PUSH: begin
                    // hold the newest join back until we know whether it closes the run
                    if (!r_pend_v || out_free) begin
                        if (r_pend_v) begin
                            r_od.tree_from        <= r_pend.f;
                            r_od.tree_to          <= r_pend.t;
                            r_od.tree_weight      <= 32'(48'(r_pend.w));
                            r_od.tree_valid       <= 1'b1;
                            r_od.tree_last        <= 1'b0;
                            r_od.edges_dropped    <= r_ovf;
                        end
                        r_pend   <= r_e;
                        r_pend_v <= 1'b1;
                        r_nres   <= r_nres + RCW'(1);
                        if (last_k) begin
                            r_state <= S_END;
                        end else begin
                            r_k     <= r_k + IDX_W'(1);
                            r_state <= S_OK;
                        end
                    end
                end
                S_END: begin
                    if (out_free) begin
                        r_od.tree_from     <= r_pend_v ? r_pend.f : '0;
                        r_od.tree_to       <= r_pend_v ? r_pend.t : '0;
                        r_od.tree_weight   <= r_pend_v ? 32'(48'(r_pend.w)) : '0;
                        r_od.tree_valid    <= r_pend_v;
                        r_od.tree_last     <= 1'b1;
                        r_od.edges_dropped <= r_ovf;
                        r_pend_v           <= 1'b0;
                        r_cnt              <= '0;
                        r_state            <= S_LOAD;
                    end
                end
                default: begin
                    r_state <= S_LOAD;
                end
            endcase
        end
    end

endmodule
`default_nettype wire

// File: rtl/kruskal_spanning_tree_unit.sv
// Minimum spanning tree engine. Edges stream in on i_edge at one per cycle while
// the queue has room and land in a four-entry queue; the back end drains it into
// the edge store at one per cycle while loading. An edge marked last_edge starts
// the run: each stored edge is ranked by a full pass over the store, using the
// single compare on the store's two read ports, then edges are scanned in weight
// order with union-find, where each find walks parent hops and a join may also
// raise a rank, all through the one-port node table. Joining edges leave on
// o_tree in order, the final one marked tree_last; a run with no joining edge
// gives one item with tree_valid low. While a run is in progress the queue
// keeps accepting the next set's edges until it holds four.
`default_nettype none
`include "assert_macros.svh"
module kruskal_spanning_tree_unit #(
    parameter int MAX_NODES   = 64,
    parameter int MAX_EDGES   = 256,
    parameter int WEIGHT_BITS = 32
) (
    input  wire logic   i_clk,
    input  wire logic   i_rst_n,
    krsk_edge_if.sink   i_edge,
    krsk_tree_if.source o_tree
);

    logic            q_push;
    logic            q_full;
    logic            q_valid;
    logic            q_pop;
    krsk_pkg::t_qent q_in;
    krsk_pkg::t_qent q_out;
    logic            out_empty;
    logic            out_zero;

    krsk_front #(
        .MAX_EDGES (MAX_EDGES)
    ) u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_edge  (i_edge),
        .i_full  (q_full),
        .o_push  (q_push),
        .o_ent   (q_in)
    );

    krsk_fifo u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (q_push),
        .i_data  (q_in),
        .o_full  (q_full),
        .o_valid (q_valid),
        .o_data  (q_out),
        .i_pop   (q_pop)
    );

    krsk_back #(
        .MAX_NODES   (MAX_NODES),
        .MAX_EDGES   (MAX_EDGES),
        .WEIGHT_BITS (WEIGHT_BITS)
    ) u_back (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (q_valid),
        .i_ent   (q_out),
        .o_pop   (q_pop),
        .o_tree  (o_tree)
    );

    assign out_empty = o_tree.valid && !o_tree.data.tree_valid;
    assign out_zero  = (o_tree.data.tree_from == '0) && (o_tree.data.tree_to == '0)
                       && (o_tree.data.tree_weight == '0);

    `KRSK_ASSERT_NEVER(a_push_when_full, q_push && q_full)
    `KRSK_ASSERT_IMPLY(a_empty_run_is_last, out_empty, o_tree.data.tree_last)
    `KRSK_ASSERT_IMPLY(a_empty_run_zero, out_empty, out_zero)

endmodule
`default_nettype wire
